@@ hdl/gdef_pkg.sv @@
// Shared types and constants for the grid dead-end filler.
package gdef_pkg;

  localparam int unsigned MaxRowsDef = 32;
  localparam int unsigned MaxColsDef = 32;
  localparam int unsigned GridAwDef  = 10;

  localparam int unsigned RowW    = 5;
  localparam int unsigned ColW    = 5;
  localparam int unsigned DimW    = 6;
  localparam int unsigned CntW    = 11;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [DimW-1:0] DimReset = DimW'(32);
  localparam logic [CntW-1:0] CntMax   = {CntW{1'b1}};

  // a cell is interior only when the grid has at least this many rows and columns
  localparam int unsigned MinDim    = 3;
  localparam int unsigned WallLimit = 3;
  localparam int unsigned NumDirs   = 4;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgRows = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgCols = CfgIdxW'(1);

  // step directions, also the neighbor read order
  localparam logic [1:0] DirUp    = 2'd0;
  localparam logic [1:0] DirRight = 2'd1;
  localparam logic [1:0] DirDown  = 2'd2;
  localparam logic [1:0] DirLeft  = 2'd3;

  typedef enum logic [1:0] {
    CmdWrite = 2'd0,
    CmdRun   = 2'd1,
    CmdRead  = 2'd2,
    CmdNop   = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e            cmd;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic            wall_in;
  } req_t;

  typedef struct packed {
    logic            wall_out;
    logic [CntW-1:0] dead_ends_found;
  } rsp_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ctl_stat_t;

endpackage

@@ hdl/gdef_ram.sv @@
// One-bit-wide synchronous RAM, one write port and one registered read port.
module gdef_ram #(
  parameter int unsigned AW = gdef_pkg::GridAwDef
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic          wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic          rdata_o
);

  logic mem_q [2**AW];
  logic rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/gdef_ctrl.sv @@
// Command sequencer: grid access, dead-end scan and fill walks, result pipeline.
module gdef_ctrl #(
  parameter int unsigned MAX_ROWS = gdef_pkg::MaxRowsDef,
  parameter int unsigned MAX_COLS = gdef_pkg::MaxColsDef
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        start_i,
  input  gdef_pkg::req_t                              req_i,
  input  logic [gdef_pkg::DimW-1:0]                   rows_cfg_i,
  input  logic [gdef_pkg::DimW-1:0]                   cols_cfg_i,
  output gdef_pkg::ctl_stat_t                         stat_o,
  output gdef_pkg::rsp_t                              rsp_o,
  output logic                                        grid_we_o,
  output logic [$clog2(MAX_ROWS)+$clog2(MAX_COLS)-1:0] grid_waddr_o,
  output logic                                        grid_wdata_o,
  output logic [$clog2(MAX_ROWS)+$clog2(MAX_COLS)-1:0] grid_raddr_o,
  input  logic                                        grid_rdata_i,
  output logic                                        mark_we_o,
  output logic [$clog2(MAX_ROWS)+$clog2(MAX_COLS)-1:0] mark_waddr_o,
  output logic                                        mark_wdata_o,
  output logic [$clog2(MAX_ROWS)+$clog2(MAX_COLS)-1:0] mark_raddr_o,
  input  logic                                        mark_rdata_i
);

  import gdef_pkg::*;

  localparam int unsigned RW  = $clog2(MAX_ROWS);
  localparam int unsigned CW  = $clog2(MAX_COLS);
  localparam int unsigned RDW = $clog2(MAX_ROWS + 1);
  localparam int unsigned CDW = $clog2(MAX_COLS + 1);

  localparam logic [2:0] RdCenter = 3'(NumDirs);
  localparam logic [2:0] NrScan   = 3'(NumDirs + 1);
  localparam logic [2:0] NrWalk   = 3'(NumDirs);

  localparam logic [3:0] StIdle     = 4'd0;
  localparam logic [3:0] StScanRd   = 4'd1;
  localparam logic [3:0] StScanEval = 4'd2;
  localparam logic [3:0] StMarkRd   = 4'd3;
  localparam logic [3:0] StMarkChk  = 4'd4;
  localparam logic [3:0] StMarkAdv  = 4'd5;
  localparam logic [3:0] StWalkRd   = 4'd6;
  localparam logic [3:0] StWalkEval = 4'd7;
  localparam logic [3:0] StFinish   = 4'd8;

  logic [3:0]    state_q, state_d;
  logic [RW-1:0] scan_r_q, scan_r_d, cur_r_q, cur_r_d;
  logic [CW-1:0] scan_c_q, scan_c_d, cur_c_q, cur_c_d;
  logic [1:0]    dir_q, dir_d;
  logic          dir_vld_q, dir_vld_d;
  logic [2:0]    rd_k_q, rd_k_d, pend_k_q, pend_k_d;
  logic          pend_q, pend_d;
  logic [3:0]    nbr_q, nbr_d;
  logic          ctr_q, ctr_d;
  logic [CntW-1:0] total_q, total_d;
  logic          s1_vld_q, s1_vld_d, s1_rd_q, s1_rd_d;
  logic          done_q;
  rsp_t          rsp_q;

  logic [RDW-1:0] eff_rows;
  logic [CDW-1:0] eff_cols;
  logic           has_interior, accept, req_inside;
  logic [RW-1:0]  last_r, up_r, down_r, next_r, move_r;
  logic [CW-1:0]  last_c, left_c, right_c, next_c, move_c;
  logic           scan_at_end;
  logic [3:0]     nbr_ok;
  logic [2:0]     nreads, wall_cnt;
  logic           is_dead, ahead_open, open_found;
  logic [1:0]     open_dir, move_dir;
  logic [RW+CW-1:0] req_addr, cur_addr, nbr_addr;

  // effective grid size: register value clipped to the build size
  always_comb begin
    if (int'(rows_cfg_i) > MAX_ROWS) eff_rows = RDW'(MAX_ROWS);
    else                             eff_rows = RDW'(rows_cfg_i);
    if (int'(cols_cfg_i) > MAX_COLS) eff_cols = CDW'(MAX_COLS);
    else                             eff_cols = CDW'(cols_cfg_i);
  end

  assign has_interior = (int'(eff_rows) >= MinDim) && (int'(eff_cols) >= MinDim);
  assign last_r       = RW'(eff_rows - RDW'(2));
  assign last_c       = CW'(eff_cols - CDW'(2));
  assign accept       = start_i && (state_q == StIdle);
  assign req_inside   = (int'(req_i.row) < int'(eff_rows)) && (int'(req_i.col) < int'(eff_cols));
  assign req_addr     = {RW'(req_i.row), CW'(req_i.col)};
  assign cur_addr     = {cur_r_q, cur_c_q};

  // raster position of the next interior cell
  assign scan_at_end = (scan_r_q == last_r) && (scan_c_q == last_c);
  always_comb begin
    if (scan_c_q == last_c) begin
      next_c = CW'(1);
      next_r = scan_r_q + RW'(1);
    end else begin
      next_c = scan_c_q + CW'(1);
      next_r = scan_r_q;
    end
  end

  // neighbors of the cell under evaluation
  assign up_r    = cur_r_q - RW'(1);
  assign down_r  = cur_r_q + RW'(1);
  assign left_c  = cur_c_q - CW'(1);
  assign right_c = cur_c_q + CW'(1);

  always_comb begin
    nbr_ok[DirUp]    = cur_r_q != '0;
    nbr_ok[DirRight] = (int'(cur_c_q) + 1) < int'(eff_cols);
    nbr_ok[DirDown]  = (int'(cur_r_q) + 1) < int'(eff_rows);
    nbr_ok[DirLeft]  = cur_c_q != '0;
  end

  always_comb begin
    case (rd_k_q)
      {1'b0, DirUp}:    nbr_addr = {up_r, cur_c_q};
      {1'b0, DirRight}: nbr_addr = {cur_r_q, right_c};
      {1'b0, DirDown}:  nbr_addr = {down_r, cur_c_q};
      {1'b0, DirLeft}:  nbr_addr = {cur_r_q, left_c};
      default:          nbr_addr = cur_addr;
    endcase
  end

  assign nreads   = (state_q == StScanRd) ? NrScan : NrWalk;
  assign wall_cnt = 3'($countones(nbr_q));
  assign is_dead  = !ctr_q && (int'(wall_cnt) >= WallLimit);

  // first open neighbor in up, right, down, left order
  always_comb begin
    open_found = 1'b0;
    open_dir   = DirUp;
    for (int d = NumDirs - 1; d >= 0; d--) begin
      if (!nbr_q[d]) begin
        open_found = 1'b1;
        open_dir   = 2'(d);
      end
    end
  end

  assign ahead_open = dir_vld_q && !nbr_q[dir_q];
  assign move_dir   = ahead_open ? dir_q : open_dir;

  always_comb begin
    move_r = cur_r_q;
    move_c = cur_c_q;
    case (move_dir)
      DirUp:    move_r = up_r;
      DirRight: move_c = right_c;
      DirDown:  move_r = down_r;
      default:  move_c = left_c;
    endcase
  end

  assign grid_raddr_o = (state_q == StIdle) ? req_addr : nbr_addr;
  assign mark_raddr_o = {scan_r_q, scan_c_q};
  assign mark_waddr_o = {scan_r_q, scan_c_q};

  always_comb begin
    state_d   = state_q;
    scan_r_d  = scan_r_q;
    scan_c_d  = scan_c_q;
    cur_r_d   = cur_r_q;
    cur_c_d   = cur_c_q;
    dir_d     = dir_q;
    dir_vld_d = dir_vld_q;
    rd_k_d    = rd_k_q;
    pend_d    = 1'b0;
    pend_k_d  = pend_k_q;
    nbr_d     = nbr_q;
    ctr_d     = ctr_q;
    total_d   = total_q;
    s1_vld_d  = 1'b0;
    s1_rd_d   = 1'b0;
    grid_we_o    = 1'b0;
    grid_waddr_o = req_addr;
    grid_wdata_o = req_i.wall_in;
    mark_we_o    = 1'b0;
    mark_wdata_o = 1'b0;

    // capture read data; neighbors off the grid count as walls
    if (pend_q) begin
      if (pend_k_q == RdCenter) ctr_d = grid_rdata_i;
      else nbr_d[pend_k_q[1:0]] = grid_rdata_i | ~nbr_ok[pend_k_q[1:0]];
    end

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          case (req_i.cmd)
            CmdWrite: begin
              grid_we_o = req_inside;
              s1_vld_d  = 1'b1;
            end
            CmdRun: begin
              total_d = '0;
              if (has_interior) begin
                scan_r_d = RW'(1);
                scan_c_d = CW'(1);
                cur_r_d  = RW'(1);
                cur_c_d  = CW'(1);
                rd_k_d   = '0;
                state_d  = StScanRd;
              end else begin
                state_d = StFinish;
              end
            end
            CmdRead: begin
              s1_vld_d = 1'b1;
              s1_rd_d  = req_inside;
            end
            default: s1_vld_d = 1'b1;
          endcase
        end
      end
      StScanRd, StWalkRd: begin
        if (rd_k_q < nreads) begin
          pend_d   = 1'b1;
          pend_k_d = rd_k_q;
          rd_k_d   = rd_k_q + 3'd1;
        end else if (pend_q) begin
          state_d = (state_q == StScanRd) ? StScanEval : StWalkEval;
        end
      end
      StScanEval: begin
        mark_we_o    = 1'b1;
        mark_wdata_o = is_dead;
        if (is_dead && (total_q != CntMax)) total_d = total_q + CntW'(1);
        if (scan_at_end) begin
          scan_r_d = RW'(1);
          scan_c_d = CW'(1);
          state_d  = StMarkRd;
        end else begin
          scan_r_d = next_r;
          scan_c_d = next_c;
          cur_r_d  = next_r;
          cur_c_d  = next_c;
          rd_k_d   = '0;
          state_d  = StScanRd;
        end
      end
      StMarkRd: state_d = StMarkChk;
      StMarkChk: begin
        if (mark_rdata_i) begin
          cur_r_d   = scan_r_q;
          cur_c_d   = scan_c_q;
          dir_vld_d = 1'b0;
          rd_k_d    = '0;
          state_d   = StWalkRd;
        end else begin
          state_d = StMarkAdv;
        end
      end
      StMarkAdv: begin
        if (scan_at_end) begin
          state_d = StFinish;
        end else begin
          scan_r_d = next_r;
          scan_c_d = next_c;
          state_d  = StMarkRd;
        end
      end
      StWalkEval: begin
        if (int'(wall_cnt) < WallLimit) begin
          state_d = StMarkAdv;
        end else begin
          grid_we_o    = 1'b1;
          grid_waddr_o = cur_addr;
          grid_wdata_o = 1'b1;
          if (ahead_open || open_found) begin
            dir_d     = move_dir;
            dir_vld_d = 1'b1;
            cur_r_d   = move_r;
            cur_c_d   = move_c;
            rd_k_d    = '0;
            state_d   = StWalkRd;
          end else begin
            state_d = StMarkAdv;
          end
        end
      end
      StFinish: begin
        s1_vld_d = 1'b1;
        state_d  = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      rd_k_q    <= '0;
      pend_q    <= 1'b0;
      dir_vld_q <= 1'b0;
      total_q   <= '0;
      s1_vld_q  <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_k_q    <= rd_k_d;
      pend_q    <= pend_d;
      dir_vld_q <= dir_vld_d;
      total_q   <= total_d;
      s1_vld_q  <= s1_vld_d;
      done_q    <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_r_q <= scan_r_d;
    scan_c_q <= scan_c_d;
    cur_r_q  <= cur_r_d;
    cur_c_q  <= cur_c_d;
    dir_q    <= dir_d;
    pend_k_q <= pend_k_d;
    nbr_q    <= nbr_d;
    ctr_q    <= ctr_d;
    s1_rd_q  <= s1_rd_d;
    rsp_q.wall_out        <= s1_rd_q & grid_rdata_i;
    rsp_q.dead_ends_found <= total_q;
  end

  assign stat_o = '{busy: (state_q != StIdle), done: done_q};
  assign rsp_o  = rsp_q;

endmodule

@@ hdl/grid_dead_end_filler.sv @@
// Top level of the grid dead-end filler: configuration registers, grid and mark memories.
//
// The block holds a grid of wall bits in a one-bit RAM and takes one request when
// start_i is high and busy_o is low. A write (cmd 0) or read (cmd 2) request is a
// single grid RAM access: a new one can be taken every cycle, and its result shows
// on rsp_o after the s1 stage and the result register, for one cycle, marked by
// done_o. There is no backpressure on the result side; the receiver must take
// done_o when it comes. A run (cmd 1) raises busy_o for its whole length and then
// returns one result with the dead-end count. All grid cell reads go through the
// single read port of the grid RAM, one per cycle, and that port sets the run
// length: the scan reads four neighbors and the center of each interior cell, a
// sweep checks the dead-end marks, each walk step reads four neighbors and decides,
// and a finish state ends the run. A walk step is one per filled cell, plus one for
// a walk that ends on a cell with fewer than three walls. After busy_o falls, the
// result strobe still passes the done register. Rows and columns in use are clipped
// to MAX_ROWS and MAX_COLS; below three of either a run finds nothing. Grid cells
// are undefined until written, and a run over unwritten cells gives undefined counts.
// The user must write configuration only while idle; the block does not enforce it.
module grid_dead_end_filler #(
  parameter int unsigned MAX_ROWS = gdef_pkg::MaxRowsDef,
  parameter int unsigned MAX_COLS = gdef_pkg::MaxColsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  gdef_pkg::req_t               req_i,
  output logic                         busy_o,
  output logic                         done_o,
  output gdef_pkg::rsp_t               rsp_o,
  input  logic                         cfg_we_i,
  input  logic [gdef_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [gdef_pkg::DimW-1:0]    cfg_wdata_i
);

  import gdef_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ROWS) + $clog2(MAX_COLS);

  logic [DimW-1:0] rows_q, rows_d, cols_q, cols_d;
  ctl_stat_t       stat;
  logic            grid_we, grid_wdata, grid_rdata;
  logic            mark_we, mark_wdata, mark_rdata;
  logic [AW-1:0]   grid_waddr, grid_raddr, mark_waddr, mark_raddr;

  // configuration decode; unknown indexes are dropped
  always_comb begin
    rows_d = rows_q;
    cols_d = cols_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgRows: rows_d = cfg_wdata_i;
        CfgCols: cols_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= DimReset;
      cols_q <= DimReset;
    end else begin
      rows_q <= rows_d;
      cols_q <= cols_d;
    end
  end

  gdef_ctrl #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .req_i        (req_i),
    .rows_cfg_i   (rows_q),
    .cols_cfg_i   (cols_q),
    .stat_o       (stat),
    .rsp_o        (rsp_o),
    .grid_we_o    (grid_we),
    .grid_waddr_o (grid_waddr),
    .grid_wdata_o (grid_wdata),
    .grid_raddr_o (grid_raddr),
    .grid_rdata_i (grid_rdata),
    .mark_we_o    (mark_we),
    .mark_waddr_o (mark_waddr),
    .mark_wdata_o (mark_wdata),
    .mark_raddr_o (mark_raddr),
    .mark_rdata_i (mark_rdata)
  );

  // wall bits, row-major
  gdef_ram #(.AW(AW)) u_grid_ram (
    .clk_i   (clk_i),
    .we_i    (grid_we),
    .waddr_i (grid_waddr),
    .wdata_i (grid_wdata),
    .raddr_i (grid_raddr),
    .rdata_o (grid_rdata)
  );

  // dead-end snapshot; every interior entry is rewritten by the scan of each run
  gdef_ram #(.AW(AW)) u_mark_ram (
    .clk_i   (clk_i),
    .we_i    (mark_we),
    .waddr_i (mark_waddr),
    .wdata_i (mark_wdata),
    .raddr_i (mark_raddr),
    .rdata_o (mark_rdata)
  );

  assign busy_o = stat.busy;
  assign done_o = stat.done;

endmodule

@@ hdl/gdef_checker.sv @@
// Port-level checks for the grid dead-end filler, bound to the top level.
module gdef_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start_i,
  input gdef_pkg::req_t req_i,
  input logic           busy_o,
  input logic           done_o,
  input gdef_pkg::rsp_t rsp_o
);

  import gdef_pkg::*;

  // a run request holds off further requests
  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (req_i.cmd == CmdRun) |=> busy_o)
    else $error("run request did not raise busy");

  // every non-run request is answered with done_o
  a_access_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (req_i.cmd != CmdRun) |=> ##1 done_o)
    else $error("missing result for access request");

  // end of a run gives its result
  a_run_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |=> done_o)
    else $error("missing result at end of run");

  // a set wall bit only comes from a read request
  a_wall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.wall_out |-> $past(start_i && !busy_o && (req_i.cmd == CmdRead), 2))
    else $error("wall_out set on a non-read result");

endmodule

bind grid_dead_end_filler gdef_checker u_gdef_checker (.*);
